>>> rtl/position_window_average_core_assert.svh
// assertion macros for the window average core
`ifndef POSITION_WINDOW_AVERAGE_CORE_ASSERT_SVH
`define POSITION_WINDOW_AVERAGE_CORE_ASSERT_SVH
`ifndef SYNTH
`define PWA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define PWA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define PWA_ASSERT_IMP(lbl, ante, cons)
`define PWA_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> rtl/pwa_pkg.sv
`default_nettype none
package pwa_pkg;
    localparam int DEPTH_DEFAULT = 1024;
    localparam int FRAC_DEFAULT  = 16;
    localparam int POS_W    = 32;
    localparam int SCORE_W  = 32;
    localparam int WIN_W    = 33;
    localparam int SIZE_W   = 24;
    localparam int MODE_W   = 2;
    localparam int THR_W    = 31;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;
    localparam int DIVISOR_W  = 24;

    localparam logic [SIZE_W-1:0] WINDOW_SIZE_RESET = 24'd5000;
    localparam logic [SIZE_W-1:0] STEP_SIZE_RESET   = 24'd1000;
    localparam logic [THR_W-1:0]  THRESHOLD_RESET   = 31'd163840;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MODE        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TRUNCATE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD   = 3'd4;

    localparam logic [MODE_W-1:0] MODE_ABS = 2'd1;
    localparam logic [MODE_W-1:0] MODE_D   = 2'd2;

    typedef struct packed {
        logic load_item;
        logic start_stat;
        logic start_slide;
        logic apply_slide;
        logic rd_back;
        logic evict;
        logic insert;
        logic capture_back;
        logic load_out;
        logic out_final;
        logic clear_seq;
    } pwa_cmd_t;

    typedef struct packed {
        logic past_end;
        logic fill_nz;
        logic div_done;
        logic evict_ok;
        logic eos;
        logic truncate;
        logic out_free;
    } pwa_status_t;
endpackage
`default_nettype wire

>>> rtl/pwa_ram.sv
`default_nettype none
module pwa_ram #(
    parameter int WIDTH = 65,
    parameter int DEPTH = pwa_pkg::DEPTH_DEFAULT
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

>>> rtl/pwa_div.sv
`default_nettype none
module pwa_div #(
    parameter int DW = 43,
    parameter int VW = pwa_pkg::DIVISOR_W
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          start,
    input  wire logic [DW-1:0] dividend,
    input  wire logic [VW-1:0] divisor,
    output logic               done,
    output logic      [DW-1:0] quotient,
    output logic      [VW-1:0] remainder
);
    localparam int CW = $clog2(DW + 1);

    logic [VW:0]   rem_reg, rem_next;
    logic [DW-1:0] quo_reg, quo_next;
    logic [VW-1:0] dvs_reg;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [VW:0]   trial;
    logic [VW:0]   diff;

    assign trial = {rem_reg[VW-1:0], quo_reg[DW-1]};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            cnt_next  = CW'(DW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next = diff;
                quo_next = {quo_reg[DW-2:0], 1'b1};
            end else begin
                rem_next = trial;
                quo_next = {quo_reg[DW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start) begin
            dvs_reg <= divisor;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg[VW-1:0];
endmodule
`default_nettype wire

>>> rtl/pwa_ctrl.sv
`default_nettype none
module pwa_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire pwa_pkg::pwa_status_t status,
    output pwa_pkg::pwa_cmd_t        cmd
);
    typedef enum logic [9:0] {
        ST_IDLE      = 10'b0000000001,
        ST_CHECK     = 10'b0000000010,
        ST_STAT      = 10'b0000000100,
        ST_EMIT      = 10'b0000001000,
        ST_SLIDE     = 10'b0000010000,
        ST_EVICT_RD  = 10'b0000100000,
        ST_EVICT_CHK = 10'b0001000000,
        ST_INSERT    = 10'b0010000000,
        ST_FINAL     = 10'b0100000000,
        ST_BACK_CAP  = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;
    logic   final_reg, final_next;

    always_comb begin
        state_next = state_reg;
        final_next = final_reg;
        cmd        = '0;
        cmd.out_final = final_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (status.past_end && status.fill_nz) begin
                    cmd.start_stat = 1'b1;
                    final_next     = 1'b0;
                    state_next     = ST_STAT;
                end else if (status.past_end) begin
                    cmd.start_slide = 1'b1;
                    state_next      = ST_SLIDE;
                end else begin
                    state_next = ST_INSERT;
                end
            end
            ST_STAT: begin
                if (status.div_done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    if (final_reg) begin
                        cmd.clear_seq = 1'b1;
                        state_next    = ST_IDLE;
                    end else begin
                        cmd.start_slide = 1'b1;
                        state_next      = ST_SLIDE;
                    end
                end
            end
            ST_SLIDE: begin
                if (status.div_done) begin
                    cmd.apply_slide = 1'b1;
                    state_next      = ST_EVICT_RD;
                end
            end
            ST_EVICT_RD: begin
                state_next = ST_EVICT_CHK;
            end
            ST_EVICT_CHK: begin
                if (status.evict_ok) begin
                    cmd.evict  = 1'b1;
                    state_next = ST_EVICT_RD;
                end else begin
                    state_next = ST_INSERT;
                end
            end
            ST_INSERT: begin
                cmd.insert = 1'b1;
                state_next = status.eos ? ST_FINAL : ST_IDLE;
            end
            ST_FINAL: begin
                if (status.truncate) begin
                    cmd.rd_back = 1'b1;
                    state_next  = ST_BACK_CAP;
                end else begin
                    cmd.start_stat = 1'b1;
                    final_next     = 1'b1;
                    state_next     = ST_STAT;
                end
            end
            ST_BACK_CAP: begin
                cmd.capture_back = 1'b1;
                cmd.start_stat   = 1'b1;
                final_next       = 1'b1;
                state_next       = ST_STAT;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            final_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            final_reg <= final_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
endmodule
`default_nettype wire

>>> rtl/pwa_datapath.sv
`default_nettype none
module pwa_datapath #(
    parameter int WINDOW_DEPTH  = pwa_pkg::DEPTH_DEFAULT,
    parameter int FRACTION_BITS = pwa_pkg::FRAC_DEFAULT,
    localparam int CNT_W = $clog2(WINDOW_DEPTH + 1)
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire pwa_pkg::pwa_cmd_t                 cmd,
    output pwa_pkg::pwa_status_t                   status,
    input  wire logic                              cfg_valid,
    input  wire logic [pwa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [pwa_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic [pwa_pkg::POS_W-1:0]         s_position,
    input  wire logic signed [pwa_pkg::SCORE_W-1:0] s_score,
    input  wire logic                              s_end_of_sequence,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [pwa_pkg::WIN_W-1:0]              m_window_start,
    output logic [pwa_pkg::WIN_W-1:0]              m_window_end,
    output logic [CNT_W-1:0]                       m_item_count,
    output logic signed [pwa_pkg::SCORE_W-1:0]     m_statistic,
    output logic [CNT_W-1:0]                       m_count_at_or_above,
    output logic                                   m_overflow_seen,
    output logic                                   m_last_result
);
    localparam int IDX_W = $clog2(WINDOW_DEPTH);
    localparam int SUM_W = pwa_pkg::SCORE_W + CNT_W;
    localparam int DW    = SUM_W;
    localparam int VW    = pwa_pkg::DIVISOR_W;
    localparam int RAM_W = pwa_pkg::POS_W + pwa_pkg::SCORE_W + 1;
    localparam int PW    = CNT_W + 1;
    localparam int WW    = pwa_pkg::WIN_W;

    logic [pwa_pkg::SIZE_W-1:0] ws_reg, step_reg;
    logic [pwa_pkg::MODE_W-1:0] mode_reg;
    logic                       trunc_reg;
    logic [pwa_pkg::THR_W-1:0]  thr_reg;

    logic [pwa_pkg::POS_W-1:0]          pos_reg;
    logic signed [pwa_pkg::SCORE_W-1:0] score_reg;
    logic                               eos_reg;
    logic [IDX_W-1:0]                   head_reg;
    logic [CNT_W-1:0]                   fill_reg, zero_reg, above_reg;
    logic [WW-1:0]                      start_reg, end_reg, num_reg, back_end_reg;
    logic signed [SUM_W-1:0]            sum_reg;
    logic                               drop_reg, neg_reg;

    logic                               m_valid_reg;
    logic [WW-1:0]                      m_start_reg, m_end_reg;
    logic [CNT_W-1:0]                   m_cnt_reg, m_above_reg;
    logic signed [pwa_pkg::SCORE_W-1:0] m_stat_reg;
    logic                               m_ovf_reg, m_last_reg;

    logic [pwa_pkg::SIZE_W-1:0] step_eff;
    logic [WW-1:0]              slide_num, slide_inc;
    logic [PW-1:0]              two_z, n_ext, d_mag;
    logic                       d_neg, sum_neg, is_d;
    logic [SUM_W-1:0]           sum_mag;
    logic [DW-1:0]              d_dividend, div_a, quotient, q_signed;
    logic [VW-1:0]              div_b, remainder;
    logic                       div_done;
    logic [RAM_W-1:0]           ram_rdata, ram_wdata;
    logic [pwa_pkg::POS_W-1:0]  r_pos;
    logic signed [pwa_pkg::SCORE_W-1:0] r_score, ins_sc;
    logic                       r_above, above_new, full;
    logic [PW-1:0]              slot_w, back_w;
    logic [IDX_W-1:0]           slot, back, raddr, head_inc;
    logic [SUM_W-1:0]           r_score_ext, ins_ext;

    // divider operand selection
    assign step_eff  = (step_reg == '0) ? pwa_pkg::SIZE_W'(1) : step_reg;
    assign slide_num = {1'b0, pos_reg} - end_reg + WW'(step_eff) - WW'(1);
    assign slide_inc = num_reg - WW'(remainder);
    assign two_z     = {zero_reg, 1'b0};
    assign n_ext     = {1'b0, fill_reg};
    assign d_neg     = two_z > n_ext;
    assign d_mag     = d_neg ? (two_z - n_ext) : (n_ext - two_z);
    assign d_dividend = DW'(d_mag) << FRACTION_BITS;
    assign sum_neg   = sum_reg[SUM_W-1];
    assign sum_mag   = sum_neg ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign is_d      = (mode_reg == pwa_pkg::MODE_D);
    assign div_a     = cmd.start_stat ? (is_d ? d_dividend : DW'(sum_mag)) : DW'(slide_num);
    assign div_b     = cmd.start_stat ? VW'(fill_reg) : VW'(step_eff);
    assign q_signed  = neg_reg ? (~quotient + DW'(1)) : quotient;

    pwa_div #(.DW(DW), .VW(VW)) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.start_stat | cmd.start_slide),
        .dividend  (div_a),
        .divisor   (div_b),
        .done      (div_done),
        .quotient  (quotient),
        .remainder (remainder)
    );

    // window store addressing
    assign slot_w   = PW'(head_reg) + PW'(fill_reg);
    assign slot     = (slot_w >= PW'(WINDOW_DEPTH)) ? IDX_W'(slot_w - PW'(WINDOW_DEPTH))
                                                    : IDX_W'(slot_w);
    assign back_w   = slot_w - PW'(1);
    assign back     = (back_w >= PW'(WINDOW_DEPTH)) ? IDX_W'(back_w - PW'(WINDOW_DEPTH))
                                                    : IDX_W'(back_w);
    assign raddr    = cmd.rd_back ? back : head_reg;
    assign head_inc = (head_reg == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : head_reg + IDX_W'(1);
    assign full     = (fill_reg == CNT_W'(WINDOW_DEPTH));

    assign r_pos   = ram_rdata[RAM_W-1 -: pwa_pkg::POS_W];
    assign r_score = ram_rdata[pwa_pkg::SCORE_W:1];
    assign r_above = ram_rdata[0];
    assign r_score_ext = {{(SUM_W-pwa_pkg::SCORE_W){r_score[pwa_pkg::SCORE_W-1]}}, r_score};

    // absolute score in mode 1, most negative value saturates
    always_comb begin
        ins_sc = score_reg;
        if (mode_reg == pwa_pkg::MODE_ABS && score_reg < 0) begin
            if (score_reg == {1'b1, {(pwa_pkg::SCORE_W-1){1'b0}}}) begin
                ins_sc = {1'b0, {(pwa_pkg::SCORE_W-1){1'b1}}};
            end else begin
                ins_sc = -score_reg;
            end
        end
    end
    assign above_new = $signed({ins_sc[pwa_pkg::SCORE_W-1], ins_sc}) >= $signed({2'b00, thr_reg});
    assign ins_ext   = {{(SUM_W-pwa_pkg::SCORE_W){ins_sc[pwa_pkg::SCORE_W-1]}}, ins_sc};
    assign ram_wdata = {pos_reg, ins_sc, above_new};

    pwa_ram #(.WIDTH(RAM_W), .DEPTH(WINDOW_DEPTH)) u_ram (
        .aclk  (aclk),
        .we    (cmd.insert && !full),
        .waddr (slot),
        .wdata (ram_wdata),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        status.past_end = {1'b0, pos_reg} > end_reg;
        status.fill_nz  = fill_reg != '0;
        status.div_done = div_done;
        status.evict_ok = (fill_reg != '0) && ({1'b0, r_pos} < start_reg);
        status.eos      = eos_reg;
        status.truncate = trunc_reg;
        status.out_free = !m_valid_reg || m_ready;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ws_reg      <= pwa_pkg::WINDOW_SIZE_RESET;
            step_reg    <= pwa_pkg::STEP_SIZE_RESET;
            mode_reg    <= '0;
            trunc_reg   <= 1'b0;
            thr_reg     <= pwa_pkg::THR_W'(5) << (FRACTION_BITS - 1);
            head_reg    <= '0;
            fill_reg    <= '0;
            zero_reg    <= '0;
            above_reg   <= '0;
            sum_reg     <= '0;
            start_reg   <= '0;
            end_reg     <= WW'(pwa_pkg::WINDOW_SIZE_RESET);
            drop_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    pwa_pkg::REG_WINDOW_SIZE: begin
                        ws_reg  <= cfg_data[pwa_pkg::SIZE_W-1:0];
                        end_reg <= start_reg + WW'(cfg_data[pwa_pkg::SIZE_W-1:0]);
                    end
                    pwa_pkg::REG_STEP_SIZE: step_reg  <= cfg_data[pwa_pkg::SIZE_W-1:0];
                    pwa_pkg::REG_MODE:      mode_reg  <= cfg_data[pwa_pkg::MODE_W-1:0];
                    pwa_pkg::REG_TRUNCATE:  trunc_reg <= cfg_data[0];
                    pwa_pkg::REG_THRESHOLD: thr_reg   <= cfg_data[pwa_pkg::THR_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.apply_slide) begin
                start_reg <= start_reg + slide_inc;
                end_reg   <= end_reg + slide_inc;
            end
            if (cmd.evict) begin
                sum_reg  <= sum_reg - $signed(r_score_ext);
                if (r_score == '0) begin
                    zero_reg <= zero_reg - CNT_W'(1);
                end
                if (r_above) begin
                    above_reg <= above_reg - CNT_W'(1);
                end
                head_reg <= head_inc;
                fill_reg <= fill_reg - CNT_W'(1);
            end
            if (cmd.insert) begin
                if (full) begin
                    drop_reg <= 1'b1;
                end else begin
                    sum_reg  <= sum_reg + $signed(ins_ext);
                    if (ins_sc == '0) begin
                        zero_reg <= zero_reg + CNT_W'(1);
                    end
                    if (above_new) begin
                        above_reg <= above_reg + CNT_W'(1);
                    end
                    fill_reg <= fill_reg + CNT_W'(1);
                end
            end
            if (cmd.clear_seq) begin
                head_reg  <= '0;
                fill_reg  <= '0;
                zero_reg  <= '0;
                above_reg <= '0;
                sum_reg   <= '0;
                start_reg <= '0;
                end_reg   <= WW'(ws_reg);
            end
            if (cmd.load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (cmd.load_item) begin
            pos_reg   <= s_position;
            score_reg <= s_score;
            eos_reg   <= s_end_of_sequence;
        end
        if (cmd.start_stat) begin
            neg_reg <= is_d ? d_neg : sum_neg;
        end
        if (cmd.start_slide) begin
            num_reg <= slide_num;
        end
        if (cmd.capture_back) begin
            back_end_reg <= (r_pos == '0) ? '0 : WW'(r_pos - pwa_pkg::POS_W'(1));
        end
        if (cmd.load_out) begin
            m_start_reg <= start_reg;
            m_end_reg   <= (cmd.out_final && trunc_reg) ? back_end_reg : end_reg;
            m_cnt_reg   <= fill_reg;
            m_stat_reg  <= q_signed[pwa_pkg::SCORE_W-1:0];
            m_above_reg <= (mode_reg == pwa_pkg::MODE_ABS) ? above_reg : '0;
            m_ovf_reg   <= drop_reg;
            m_last_reg  <= cmd.out_final || !eos_reg;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_window_start      = m_start_reg;
    assign m_window_end        = m_end_reg;
    assign m_item_count        = m_cnt_reg;
    assign m_statistic         = m_stat_reg;
    assign m_count_at_or_above = m_above_reg;
    assign m_overflow_seen     = m_ovf_reg;
    assign m_last_result       = m_last_reg;
endmodule
`default_nettype wire

>>> rtl/position_window_average_core.sv
// Sliding window mean over sorted (position, score) items. One item at a time is taken:
// an item inside the window is accepted, checked and stored. An item past the window
// end adds one pass of the shared bit-serial divider for the slide, a read and a check
// of each evicted entry, and a read and a check of the entry that stops eviction; a
// report costs one more divider pass plus loading the output register, which also waits
// while an earlier report has not been taken. An end-of-sequence item passes through a
// final state before its final report, and a truncated final report also reads the
// window store first. The window store is a single memory with one write and one
// registered read port; its contents need no clearing after reset.
`default_nettype none
`include "position_window_average_core_assert.svh"
module position_window_average_core #(
    parameter int WINDOW_DEPTH  = pwa_pkg::DEPTH_DEFAULT,
    parameter int FRACTION_BITS = pwa_pkg::FRAC_DEFAULT,
    localparam int CNT_W = $clog2(WINDOW_DEPTH + 1)
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [pwa_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [pwa_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [pwa_pkg::POS_W-1:0]          s_position,
    input  wire logic signed [pwa_pkg::SCORE_W-1:0] s_score,
    input  wire logic                               s_end_of_sequence,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic [pwa_pkg::WIN_W-1:0]               m_window_start,
    output logic [pwa_pkg::WIN_W-1:0]               m_window_end,
    output logic [CNT_W-1:0]                        m_item_count,
    output logic signed [pwa_pkg::SCORE_W-1:0]      m_statistic,
    output logic [CNT_W-1:0]                        m_count_at_or_above,
    output logic                                    m_overflow_seen,
    output logic                                    m_last_result
);
    pwa_pkg::pwa_cmd_t    cmd;
    pwa_pkg::pwa_status_t status;

    assign cfg_ready = 1'b1;

    pwa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    pwa_datapath #(
        .WINDOW_DEPTH  (WINDOW_DEPTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cmd                 (cmd),
        .status              (status),
        .cfg_valid           (cfg_valid && cfg_ready),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .s_position          (s_position),
        .s_score             (s_score),
        .s_end_of_sequence   (s_end_of_sequence),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_window_start      (m_window_start),
        .m_window_end        (m_window_end),
        .m_item_count        (m_item_count),
        .m_statistic         (m_statistic),
        .m_count_at_or_above (m_count_at_or_above),
        .m_overflow_seen     (m_overflow_seen),
        .m_last_result       (m_last_result)
    );

    `PWA_ASSERT_NEXT(a_one_item_at_a_time, s_valid && s_ready, !s_ready)
    `PWA_ASSERT_IMP(a_report_not_empty, m_valid, m_item_count != '0)
    `PWA_ASSERT_IMP(a_count_bounded, m_valid, m_count_at_or_above <= m_item_count)
endmodule
`default_nettype wire
